@@ sv/ssm_pkg.sv @@
// Shared types, widths and register codes for the sampled sliding-window median block.
package ssm_pkg;

  // Payload widths fixed by the channel definitions
  localparam int VALUE_W    = 32;
  localparam int DRAW_W     = 16;
  localparam int WSIZE_W    = 7;
  localparam int THRESH_W   = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Defaults for the top-level parameters
  localparam int MAX_WINDOW_DEF = 64;
  localparam int DRAW_BITS_DEF  = 16;

  // Register reset values
  localparam int                    WINDOW_SIZE_RST = 64;
  localparam logic [THRESH_W-1:0]   THRESH_RST      = 17'h1_0000;

  // Cells feeding one first-level OR group of the median tap
  localparam int TAP_GROUP = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_THRESH = 4'd1;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_INSERT,
    ST_GATHER,
    ST_FINISH
  } state_t;

  // Phase strobes broadcast to every cell
  typedef struct packed {
    logic evict;
    logic insert;
  } cell_ctl_t;

  // Where a cell sits relative to the fill count and the window size
  typedef struct packed {
    logic in_range;   // index below fill count
    logic at_fill;    // index equals fill count
    logic next_out;   // neighbor above is at or past fill count
    logic tail;       // last slot of the arrival line for the window in use
  } cell_pos_t;

endpackage

@@ sv/ssm_if.sv @@
// Handshake channel interfaces: sample input, result output and configuration write.

interface ssm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ssm_pkg::VALUE_W-1:0] sample_value;
  logic        [ssm_pkg::DRAW_W-1:0]  random_draw;

  modport source (output valid, output sample_value, output random_draw, input ready);
  modport sink   (input valid, input sample_value, input random_draw, output ready);
endinterface

interface ssm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic                              median_valid;
  logic signed [ssm_pkg::VALUE_W-1:0] median_value;

  modport source (output valid, output accepted, output median_valid, output median_value,
                  input ready);
  modport sink   (input valid, input accepted, input median_valid, input median_value,
                  output ready);
endinterface

interface ssm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ssm_pkg::CFG_IDX_W-1:0]     index;
  logic [ssm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/ssm_cell.sv @@
// One window cell: a sorted slot and an arrival slot, each trading data with its neighbors.
module ssm_cell (
  input  logic                clk,
  input  ssm_pkg::cell_ctl_t  ctl,
  input  ssm_pkg::cell_pos_t  pos,
  input  ssm_pkg::value_t     old_val,
  input  ssm_pkg::value_t     new_val,
  input  ssm_pkg::value_t     prev_val,
  input  logic                prev_gt,
  input  ssm_pkg::value_t     next_val,
  input  ssm_pkg::value_t     arr_next,
  output ssm_pkg::value_t     val,
  output logic                gt,
  output ssm_pkg::value_t     arr_val
);

  ssm_pkg::value_t val_r, val_nxt;
  ssm_pkg::value_t arr_r, arr_nxt;
  logic            drop_here;

  // Occupied slot that must move up to make room for the new value
  assign gt = pos.in_range && (val_r > new_val);

  // At or above the last copy of the evicted value: pull the neighbor down
  assign drop_here = (val_r >= old_val) && (pos.next_out || (next_val > old_val));

  // Sorted slot: close the gap on evict, open it on insert
  always_comb begin
    val_nxt = val_r;
    if (ctl.evict) begin
      if (drop_here) begin
        val_nxt = next_val;
      end
    end else if (ctl.insert) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt || pos.at_fill) begin
        val_nxt = new_val;
      end
    end
  end

  // Arrival slot: advance toward cell zero, tail takes the new value
  always_comb begin
    arr_nxt = arr_r;
    if (ctl.insert) begin
      arr_nxt = pos.tail ? new_val : arr_next;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    arr_r <= arr_nxt;
  end

  assign val     = val_r;
  assign arr_val = arr_r;

endmodule

@@ sv/ssm_median_tap.sv @@
// Registered OR tree that picks the two middle sorted values out of the cell row.
module ssm_median_tap #(
  parameter int N    = ssm_pkg::MAX_WINDOW_DEF,
  parameter int CNTW = $clog2(ssm_pkg::MAX_WINDOW_DEF + 1)
) (
  input  logic              clk,
  input  logic              load,
  input  ssm_pkg::value_t   cell_val [N],
  input  logic [CNTW-1:0]   mid_lo,
  input  logic [CNTW-1:0]   mid_hi,
  output ssm_pkg::value_t   lo_val,
  output ssm_pkg::value_t   hi_val
);

  localparam int G  = ssm_pkg::TAP_GROUP;
  localparam int NG = (N + G - 1) / G;

  ssm_pkg::value_t grp_lo_r [NG];
  ssm_pkg::value_t grp_hi_r [NG];

  // First level: masked OR inside each group, registered
  for (genvar g = 0; g < NG; g++) begin : g_grp
    ssm_pkg::value_t grp_lo_nxt, grp_hi_nxt;

    always_comb begin
      grp_lo_nxt = '0;
      grp_hi_nxt = '0;
      for (int k = 0; k < G; k++) begin
        if (g * G + k < N) begin
          if (CNTW'(g * G + k) == mid_lo) begin
            grp_lo_nxt = grp_lo_nxt | cell_val[g * G + k];
          end
          if (CNTW'(g * G + k) == mid_hi) begin
            grp_hi_nxt = grp_hi_nxt | cell_val[g * G + k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        grp_lo_r[g] <= grp_lo_nxt;
        grp_hi_r[g] <= grp_hi_nxt;
      end
    end
  end

  // Second level: OR across the group registers
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int g = 0; g < NG; g++) begin
      lo_val = lo_val | grp_lo_r[g];
      hi_val = hi_val | grp_hi_r[g];
    end
  end

endmodule

@@ sv/sampled_sliding_window_median.sv @@
// Top level of the sampled sliding-window median: sequencer, cell row and median tap.
//
//   channel   direction  payload                                        transfer when
//   in_if     sink       sample_value[31:0] s, random_draw[15:0]        valid & ready
//   out_if    source     accepted, median_valid, median_value[31:0] s   valid & ready
//   cfg_if    sink       index[3:0], data[31:0]                         valid & ready
//
// Steps: a taken value with a full window goes through evict, insert, gather and
// finish in the cell row and tap; while the window is filling it skips evict, and a
// rejected value goes straight to finish. The sequencer takes the next item in the cycle after finish.
// The cell row handles one item at a time.
// Reset: synchronous active-low; clears the sequencer, fill count, held median, result
// valid flag and configuration. Cell contents are not reset and only read below the fill count.
// Stalls: the result register holds a finished result while the next item is
// accepted; finish waits for that register to drain.
module sampled_sliding_window_median #(
  parameter int MAX_WINDOW = ssm_pkg::MAX_WINDOW_DEF,
  parameter int DRAW_BITS  = ssm_pkg::DRAW_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ssm_in_if.sink    in_if,
  ssm_out_if.source out_if,
  ssm_cfg_if.sink   cfg_if
);

  localparam int CNTW     = $clog2(MAX_WINDOW + 1);
  localparam int SW       = (CNTW > ssm_pkg::WSIZE_W) ? CNTW : ssm_pkg::WSIZE_W;
  localparam int CW       = (ssm_pkg::THRESH_W > DRAW_BITS) ? ssm_pkg::THRESH_W : DRAW_BITS;
  localparam int RST_SIZE = (ssm_pkg::WINDOW_SIZE_RST > MAX_WINDOW) ?
                            MAX_WINDOW : ssm_pkg::WINDOW_SIZE_RST;

  ssm_pkg::state_t state_r, state_nxt;

  logic [CNTW-1:0]              size_r, size_nxt;
  logic [CNTW-1:0]              mid_lo_r, mid_lo_nxt;
  logic                         even_r, even_nxt;
  logic [ssm_pkg::THRESH_W-1:0] thresh_r, thresh_nxt;
  logic [CNTW-1:0]              fill_r, fill_nxt;
  ssm_pkg::value_t              held_med_r, held_med_nxt;
  logic                         held_vld_r, held_vld_nxt;
  ssm_pkg::value_t              value_r;
  logic                         take_r;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_acc_r;
  logic                         out_mvld_r;
  ssm_pkg::value_t              out_med_r;

  logic                         in_fire, cfg_fire, finish_go, tap_load;
  logic                         full, take;
  logic [CW-1:0]                draw_ext;
  logic [SW-1:0]                ws_ext;
  logic [CNTW-1:0]              mid_hi;
  ssm_pkg::cell_ctl_t           ctl;
  ssm_pkg::value_t              tap_lo, tap_hi, median;
  logic signed [ssm_pkg::VALUE_W:0] pair_sum, pair_adj;

  ssm_pkg::value_t              sval [MAX_WINDOW];
  ssm_pkg::value_t              aval [MAX_WINDOW];
  logic                         gt   [MAX_WINDOW];

  assign in_fire  = in_if.valid && in_if.ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;
  assign cfg_if.ready = 1'b1;

  // Sampling decision at the input transfer
  assign full     = (fill_r == size_r);
  assign draw_ext = CW'(in_if.random_draw) & CW'({DRAW_BITS{1'b1}});
  assign take     = !full || (draw_ext < CW'(thresh_r));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (!take) begin
            state_nxt = ssm_pkg::ST_FINISH;
          end else if (full) begin
            state_nxt = ssm_pkg::ST_EVICT;
          end else begin
            state_nxt = ssm_pkg::ST_INSERT;
          end
        end
      end
      ssm_pkg::ST_EVICT:  state_nxt = ssm_pkg::ST_INSERT;
      ssm_pkg::ST_INSERT: state_nxt = ssm_pkg::ST_GATHER;
      ssm_pkg::ST_GATHER: state_nxt = ssm_pkg::ST_FINISH;
      ssm_pkg::ST_FINISH: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = ssm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_if.ready = 1'b0;
    ctl         = '0;
    tap_load    = 1'b0;
    finish_go   = 1'b0;
    unique case (state_r)
      ssm_pkg::ST_IDLE:   in_if.ready = 1'b1;
      ssm_pkg::ST_EVICT:  ctl.evict   = 1'b1;
      ssm_pkg::ST_INSERT: ctl.insert  = 1'b1;
      ssm_pkg::ST_GATHER: tap_load    = 1'b1;
      ssm_pkg::ST_FINISH: finish_go   = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  // Configuration: saturate the window size and precompute the middle index
  assign ws_ext = SW'(cfg_if.data[ssm_pkg::WSIZE_W-1:0]);

  always_comb begin
    size_nxt   = size_r;
    mid_lo_nxt = mid_lo_r;
    even_nxt   = even_r;
    thresh_nxt = thresh_r;
    if (cfg_fire) begin
      unique case (cfg_if.index)
        ssm_pkg::CFG_WINDOW_SIZE: begin
          if (ws_ext == '0) begin
            size_nxt = CNTW'(1);
          end else if (ws_ext > SW'(MAX_WINDOW)) begin
            size_nxt = CNTW'(MAX_WINDOW);
          end else begin
            size_nxt = CNTW'(ws_ext);
          end
          mid_lo_nxt = (size_nxt - CNTW'(1)) >> 1;
          even_nxt   = !size_nxt[0];
        end
        ssm_pkg::CFG_SAMPLE_THRESH: thresh_nxt = cfg_if.data[ssm_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Fill count: drop on evict, grow on insert, empty on a size write
  always_comb begin
    fill_nxt = fill_r;
    if (cfg_fire && (cfg_if.index == ssm_pkg::CFG_WINDOW_SIZE)) begin
      fill_nxt = '0;
    end else if (ctl.evict) begin
      fill_nxt = fill_r - CNTW'(1);
    end else if (ctl.insert) begin
      fill_nxt = fill_r + CNTW'(1);
    end
  end

  // Median of the middle slot, or of the two middle slots halved toward zero for even sizes
  assign pair_sum = {tap_lo[ssm_pkg::VALUE_W-1], tap_lo} + {tap_hi[ssm_pkg::VALUE_W-1], tap_hi};
  assign pair_adj = pair_sum + (ssm_pkg::VALUE_W + 1)'(pair_sum[ssm_pkg::VALUE_W]);
  assign median   = even_r ? pair_adj[ssm_pkg::VALUE_W:1] : tap_lo;

  // Held median: update when a taken value finishes, clear on a size write
  always_comb begin
    held_med_nxt = held_med_r;
    held_vld_nxt = held_vld_r;
    if (cfg_fire && (cfg_if.index == ssm_pkg::CFG_WINDOW_SIZE)) begin
      held_med_nxt = '0;
      held_vld_nxt = 1'b0;
    end else if (finish_go && take_r) begin
      if (full) begin
        held_med_nxt = median;
        held_vld_nxt = 1'b1;
      end else begin
        held_med_nxt = '0;
        held_vld_nxt = 1'b0;
      end
    end
  end

  // Result register: load on finish, drop after its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssm_pkg::ST_IDLE;
      size_r      <= CNTW'(RST_SIZE);
      mid_lo_r    <= CNTW'((RST_SIZE - 1) / 2);
      even_r      <= ((RST_SIZE % 2) == 0);
      thresh_r    <= ssm_pkg::THRESH_RST;
      fill_r      <= '0;
      held_med_r  <= '0;
      held_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      mid_lo_r    <= mid_lo_nxt;
      even_r      <= even_nxt;
      thresh_r    <= thresh_nxt;
      fill_r      <= fill_nxt;
      held_med_r  <= held_med_nxt;
      held_vld_r  <= held_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_r <= in_if.sample_value;
      take_r  <= take;
    end
    if (finish_go) begin
      out_acc_r  <= take_r;
      out_mvld_r <= held_vld_nxt;
      out_med_r  <= held_med_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.accepted     = out_acc_r;
  assign out_if.median_valid = out_mvld_r;
  assign out_if.median_value = out_med_r;

  // Cell row
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    ssm_pkg::cell_pos_t pos;
    ssm_pkg::value_t    prev_v, next_v, arr_n;
    logic               prev_g;

    assign pos.in_range = CNTW'(i) < fill_r;
    assign pos.at_fill  = CNTW'(i) == fill_r;
    assign pos.next_out = CNTW'(i + 1) >= fill_r;
    assign pos.tail     = CNTW'(i + 1) == size_r;

    if (i == 0) begin : g_first
      assign prev_v = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_v = sval[i-1];
      assign prev_g = gt[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign next_v = sval[i];
      assign arr_n  = aval[i];
    end else begin : g_inner
      assign next_v = sval[i+1];
      assign arr_n  = aval[i+1];
    end

    ssm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pos      (pos),
      .old_val  (aval[0]),
      .new_val  (value_r),
      .prev_val (prev_v),
      .prev_gt  (prev_g),
      .next_val (next_v),
      .arr_next (arr_n),
      .val      (sval[i]),
      .gt       (gt[i]),
      .arr_val  (aval[i])
    );
  end

  // Middle-slot tap
  assign mid_hi = mid_lo_r + CNTW'(1);

  ssm_median_tap #(
    .N    (MAX_WINDOW),
    .CNTW (CNTW)
  ) u_tap (
    .clk      (clk),
    .load     (tap_load),
    .cell_val (sval),
    .mid_lo   (mid_lo_r),
    .mid_hi   (mid_hi),
    .lo_val   (tap_lo),
    .hi_val   (tap_hi)
  );

endmodule

@@ sv/ssm_checker.sv @@
// Port-level checker for the sampled sliding-window median, bound to the top level.
module ssm_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_median_valid,
  input ssm_pkg::value_t out_median_value
);

  logic       in_fire, out_fire;
  logic [1:0] pend_r, pend_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Count items accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_fire && !out_fire) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median_value))
    else $error("stalled result changed");

  // A result without a valid median shows a zero value
  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_median_valid |-> out_median_value == '0)
    else $error("median nonzero while not valid");

  // Every result belongs to an accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending item");

  // At most one item in work besides the waiting result
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> pend_r <= 2'd1)
    else $error("input accepted with two items pending");

endmodule

bind sampled_sliding_window_median ssm_checker u_ssm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_median_valid (out_if.median_valid),
  .out_median_value (out_if.median_value)
);
